@@ rtl/core/erp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types and constants of the EMA ratio restart policy block.
// ----------------------------------------------------------------------------
package erp_pkg;

	// field widths
	localparam int FIELD_W   = 32;
	localparam int EXT_W     = 64;
	localparam int GLUE_W    = 24;
	localparam int LEVEL_W   = 16;
	localparam int AVG_W     = 32;
	localparam int ALPHA_W   = 16;
	localparam int TRIG_W    = 18;
	localparam int MIN_RUN_W = 16;

	// shared multiplier: signed 34 x signed 19
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int CMP_W   = PROD_W - 1;
	localparam int LHS_W   = AVG_W + 16;
	localparam int STEP_W  = PROD_W - 16;
	localparam int RES_W   = STEP_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_RESTART_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_ALPHA       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ALPHA       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCUSED_TRIGGER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_EMERGENCY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_FLOOR     = 3'd6;

	localparam logic [MIN_RUN_W-1:0] RST_MIN_RUN          = 16'd50;
	localparam logic [ALPHA_W-1:0]   RST_FAST_ALPHA       = 16'd3277;
	localparam logic [ALPHA_W-1:0]   RST_SLOW_ALPHA       = 16'd131;
	localparam logic [TRIG_W-1:0]    RST_FOCUSED_TRIGGER  = 18'd75366;
	localparam logic [TRIG_W-1:0]    RST_STABLE_EMERGENCY = 18'd91750;
	localparam logic [TRIG_W-1:0]    RST_STABLE_FLOOR     = 18'd58982;

	// ratio of 1.0 in Q2.16, left side of the compare when slow is zero
	localparam logic [LHS_W-1:0] ONE_Q16 = 48'h0000_0001_0000;
	localparam logic [PROD_W-1:0] ROUND_HALF = 53'd32768;

	typedef enum logic [1:0] {
		SEL_FAST,
		SEL_SLOW,
		SEL_TRIG,
		SEL_FLOOR
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     mul_go;
		mul_sel_t sel;
		logic     upd_fast;
		logic     upd_slow;
		logic     decide;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic ema_needed;
		logic gate_ok;
		logic beyond;
		logic reluctant_path;
	} dp_status_t;

endpackage

@@ rtl/core/erp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_ctrl
// Sequencer of the restart policy: steps one query through the datapath and
// owns both handshakes.
// ----------------------------------------------------------------------------
module erp_ctrl import erp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_PREP  = 12'b0000_0000_0010,
		ST_MUL_F = 12'b0000_0000_0100,
		ST_UPD_F = 12'b0000_0000_1000,
		ST_MUL_S = 12'b0000_0001_0000,
		ST_UPD_S = 12'b0000_0010_0000,
		ST_GATE  = 12'b0000_0100_0000,
		ST_RMUL1 = 12'b0000_1000_0000,
		ST_RCMP1 = 12'b0001_0000_0000,
		ST_RMUL2 = 12'b0010_0000_0000,
		ST_RCMP2 = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				if (status.active) begin
					cmd.prep = 1'b1;
					state_d  = status.ema_needed ? ST_MUL_F : ST_GATE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL_F: begin
				cmd.mul_go = 1'b1;
				cmd.sel    = SEL_FAST;
				state_d    = ST_UPD_F;
			end
			ST_UPD_F: begin
				cmd.upd_fast = 1'b1;
				cmd.sel      = SEL_FAST;
				state_d      = ST_MUL_S;
			end
			ST_MUL_S: begin
				cmd.mul_go = 1'b1;
				cmd.sel    = SEL_SLOW;
				state_d    = ST_UPD_S;
			end
			ST_UPD_S: begin
				cmd.upd_slow = 1'b1;
				cmd.sel      = SEL_SLOW;
				state_d      = ST_GATE;
			end
			ST_GATE: begin
				state_d = status.gate_ok ? ST_RMUL1 : ST_DONE;
			end
			ST_RMUL1: begin
				cmd.mul_go = 1'b1;
				cmd.sel    = SEL_TRIG;
				state_d    = ST_RCMP1;
			end
			ST_RCMP1: begin
				cmd.sel = SEL_TRIG;
				if (status.beyond) begin
					cmd.decide = 1'b1;
					state_d    = ST_DONE;
				end else if (status.reluctant_path) begin
					state_d = ST_RMUL2;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RMUL2: begin
				cmd.mul_go = 1'b1;
				cmd.sel    = SEL_FLOOR;
				state_d    = ST_RCMP2;
			end
			ST_RCMP2: begin
				cmd.sel    = SEL_FLOOR;
				cmd.decide = status.beyond;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// wait only while the previous answer is still unclaimed
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/erp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_datapath
// Configuration, policy state, captured query and the shared multiplier used
// for both EMA updates and the ratio cross-multiplies.
// ----------------------------------------------------------------------------
module erp_datapath import erp_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [FIELD_W-1:0]    restart_count,
	input  logic [FIELD_W-1:0]    conflict_count,
	input  logic [FIELD_W-1:0]    learned_count,
	input  logic [GLUE_W-1:0]     glue_average,
	input  logic [LEVEL_W-1:0]    decision_level,
	input  logic                  stable_mode,
	input  logic                  reluctant_triggered,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	output logic                  do_restart
);

	// configuration
	logic                 enable_q;
	logic [MIN_RUN_W-1:0] min_run_q;
	logic [ALPHA_W-1:0]   fast_alpha_q, slow_alpha_q;
	logic [TRIG_W-1:0]    focused_q, emergency_q, floor_q;

	// policy state
	logic [AVG_W-1:0]      fast_q, slow_q;
	logic [COUNT_BITS-1:0] learned_seen_q, car_q, rseen_q;
	logic                  seeded_q;

	// captured query
	logic [COUNT_BITS-1:0] restarts_q, conflicts_q, learned_q;
	logic [GLUE_W-1:0]     glue_q;
	logic                  level_nz_q, stable_q, reluctant_q;

	logic                  result_q, do_restart_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic [EXT_W-1:0] restarts_ext, conflicts_ext, learned_ext;

	logic                  rs_new, grow;
	logic [AVG_W-1:0]      x_w, ema_avg, upd_res;
	logic [ALPHA_W-1:0]    alpha;
	logic [TRIG_W-1:0]     trig;
	logic signed [MUL_A_W-1:0] diff, mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [STEP_W-1:0]  step;
	logic signed [RES_W-1:0]   res;
	logic [LHS_W-1:0]      lhs;
	logic [CMP_W-1:0]      rhs;
	logic [COUNT_BITS-1:0] conf_gap;

	// counters are taken modulo 2^COUNT_BITS
	assign restarts_ext  = {{(EXT_W-FIELD_W){1'b0}}, restart_count};
	assign conflicts_ext = {{(EXT_W-FIELD_W){1'b0}}, conflict_count};
	assign learned_ext   = {{(EXT_W-FIELD_W){1'b0}}, learned_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b1;
			min_run_q    <= RST_MIN_RUN;
			fast_alpha_q <= RST_FAST_ALPHA;
			slow_alpha_q <= RST_SLOW_ALPHA;
			focused_q    <= RST_FOCUSED_TRIGGER;
			emergency_q  <= RST_STABLE_EMERGENCY;
			floor_q      <= RST_STABLE_FLOOR;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RESTART_ENABLE:   enable_q     <= cfg_data[0];
				CFG_MIN_RUN:          min_run_q    <= cfg_data[MIN_RUN_W-1:0];
				CFG_FAST_ALPHA:       fast_alpha_q <= cfg_data[ALPHA_W-1:0];
				CFG_SLOW_ALPHA:       slow_alpha_q <= cfg_data[ALPHA_W-1:0];
				CFG_FOCUSED_TRIGGER:  focused_q    <= cfg_data[TRIG_W-1:0];
				CFG_STABLE_EMERGENCY: emergency_q  <= cfg_data[TRIG_W-1:0];
				CFG_STABLE_FLOOR:     floor_q      <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			restarts_q  <= restarts_ext[COUNT_BITS-1:0];
			conflicts_q <= conflicts_ext[COUNT_BITS-1:0];
			learned_q   <= learned_ext[COUNT_BITS-1:0];
			glue_q      <= glue_average;
			level_nz_q  <= |decision_level;
			stable_q    <= stable_mode;
			reluctant_q <= reluctant_triggered;
		end
		if (cmd.mul_go) begin
			prod_s1 <= mul_a * mul_b;
		end
	end

	assign rs_new = restarts_q > rseen_q;
	assign grow   = learned_q > learned_seen_q;
	assign x_w    = {glue_q, 8'b0};

	// multiplier operands
	always_comb begin
		ema_avg = (cmd.sel == SEL_SLOW) ? slow_q : fast_q;
		alpha   = (cmd.sel == SEL_SLOW) ? slow_alpha_q : fast_alpha_q;
		diff    = signed'({2'b00, x_w}) - signed'({2'b00, ema_avg});
		if (cmd.sel == SEL_FLOOR) begin
			trig = floor_q;
		end else begin
			trig = stable_q ? emergency_q : focused_q;
		end
		case (cmd.sel)
			SEL_FAST, SEL_SLOW: begin
				mul_a = diff;
				mul_b = signed'({3'b000, alpha});
			end
			default: begin
				// slow of zero counts as ratio one: rhs becomes the threshold itself
				mul_a = (slow_q == '0) ? MUL_A_W'(1) : signed'({2'b00, slow_q});
				mul_b = signed'({1'b0, trig});
			end
		endcase
	end

	// EMA step: round half up, arithmetic shift by 16, clamp to 32 bits
	always_comb begin
		rnd  = prod_s1 + signed'(ROUND_HALF);
		step = rnd[PROD_W-1:16];
		res  = signed'({{(RES_W-AVG_W){1'b0}}, ema_avg}) + signed'({step[STEP_W-1], step});
		if (res[RES_W-1]) begin
			upd_res = '0;
		end else if (|res[RES_W-2:AVG_W]) begin
			upd_res = '1;
		end else begin
			upd_res = res[AVG_W-1:0];
		end
	end

	// ratio test by cross-multiply
	assign lhs      = (slow_q == '0) ? ONE_Q16 : {fast_q, 16'b0};
	assign rhs      = prod_s1[CMP_W-1:0];
	assign conf_gap = conflicts_q - car_q;

	always_comb begin
		status.active         = enable_q && level_nz_q;
		status.ema_needed     = grow && seeded_q;
		status.gate_ok        = seeded_q && (conf_gap >= COUNT_BITS'(min_run_q));
		status.reluctant_path = stable_q && reluctant_q;
		if (cmd.sel == SEL_FLOOR) begin
			status.beyond = CMP_W'(lhs) >= rhs;
		end else begin
			status.beyond = CMP_W'(lhs) > rhs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q         <= '0;
			slow_q         <= '0;
			learned_seen_q <= '0;
			seeded_q       <= 1'b0;
			car_q          <= '0;
			rseen_q        <= '0;
			result_q       <= 1'b0;
			do_restart_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				result_q <= 1'b0;
			end
			if (cmd.prep) begin
				if (rs_new) begin
					rseen_q <= restarts_q;
				end
				if (rs_new || (grow && !seeded_q)) begin
					car_q <= conflicts_q;
				end
				if (grow) begin
					learned_seen_q <= learned_q;
					if (!seeded_q) begin
						fast_q   <= x_w;
						slow_q   <= x_w;
						seeded_q <= 1'b1;
					end
				end
			end
			if (cmd.upd_fast) begin
				fast_q <= upd_res;
			end
			if (cmd.upd_slow) begin
				slow_q <= upd_res;
			end
			if (cmd.decide) begin
				result_q <= 1'b1;
				car_q    <= conflicts_q;
				rseen_q  <= restarts_q + COUNT_BITS'(1);
			end
			if (cmd.load_out) begin
				do_restart_q <= result_q;
			end
		end
	end

	assign do_restart = do_restart_q;

endmodule

@@ rtl/core/ema_ratio_restart_policy_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_ratio_restart_policy_core
// Restart decision from a fast/slow EMA ratio of the glue average.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | counters, glue_average, level, mode bits
//  out     | out_valid / out_ready| do_restart
//  cfg     | cfg_wr_en            | cfg_index, cfg_data (write only)
//
//  One query at a time: between input transfer and result load the sequencer
//  steps the single shared multiplier (two EMA updates, up to two ratio
//  cross-multiplies).
//  A new query is taken while the previous result waits in the output register.
//  A stalled output holds the next result in the final state until taken.
//  Reset clears all policy state and restores the register defaults.
// ----------------------------------------------------------------------------
module ema_ratio_restart_policy_core import erp_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FIELD_W-1:0]    restart_count,
	input  logic [FIELD_W-1:0]    conflict_count,
	input  logic [FIELD_W-1:0]    learned_count,
	input  logic [GLUE_W-1:0]     glue_average,
	input  logic [LEVEL_W-1:0]    decision_level,
	input  logic                  stable_mode,
	input  logic                  reluctant_triggered,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  do_restart
);

	dp_cmd_t    cmd;
	dp_status_t status;

	erp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	erp_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.restart_count       (restart_count),
		.conflict_count      (conflict_count),
		.learned_count       (learned_count),
		.glue_average        (glue_average),
		.decision_level      (decision_level),
		.stable_mode         (stable_mode),
		.reluctant_triggered (reluctant_triggered),
		.cmd                 (cmd),
		.status              (status),
		.do_restart          (do_restart)
	);

endmodule

@@ tb/sv/ema_ratio_restart_policy_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_ratio_restart_policy_core_tb
// Self-checking bench for the EMA ratio restart policy core. Restart queries
// go in over a valid/ready channel with random gaps and the answers are
// taken with random stalls. A predictor tracks both EMAs, the seeding, the
// restart bookkeeping and the ratio tests, and every answer is compared
// with it. The run walks through several register settings: disabled,
// default, extreme low and high, mixed, and random.
// ----------------------------------------------------------------------------
module ema_ratio_restart_policy_core_tb import erp_pkg::*;;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] restarts;
		logic [FIELD_W-1:0] conflicts;
		logic [FIELD_W-1:0] learned;
		logic [GLUE_W-1:0]  glue;
		logic [LEVEL_W-1:0] level;
		logic               stable;
		logic               reluctant;
	} query_t;

	typedef struct {
		logic                 enable;
		logic [MIN_RUN_W-1:0] min_run;
		logic [ALPHA_W-1:0]   fast_alpha;
		logic [ALPHA_W-1:0]   slow_alpha;
		logic [TRIG_W-1:0]    focused;
		logic [TRIG_W-1:0]    emergency;
		logic [TRIG_W-1:0]    floor;
	} policy_cfg_t;

	class restart_sb;
		logic                 restart_en;
		logic [MIN_RUN_W-1:0] min_run;
		logic [ALPHA_W-1:0]   fast_alpha;
		logic [ALPHA_W-1:0]   slow_alpha;
		logic [TRIG_W-1:0]    focused_trig;
		logic [TRIG_W-1:0]    emergency_trig;
		logic [TRIG_W-1:0]    floor_trig;
		logic [AVG_W-1:0]     fast_avg;
		logic [AVG_W-1:0]     slow_avg;
		logic [FIELD_W-1:0]   learned_seen;
		logic [FIELD_W-1:0]   conflicts_at_restart;
		logic [FIELD_W-1:0]   restarts_seen;
		logic                 seeded;
		bit                   answers[$];
		int                   errors;

		function new();
			restart_en           = 1'b1;
			min_run              = RST_MIN_RUN;
			fast_alpha           = RST_FAST_ALPHA;
			slow_alpha           = RST_SLOW_ALPHA;
			focused_trig         = RST_FOCUSED_TRIGGER;
			emergency_trig       = RST_STABLE_EMERGENCY;
			floor_trig           = RST_STABLE_FLOOR;
			fast_avg             = '0;
			slow_avg             = '0;
			learned_seen         = '0;
			conflicts_at_restart = '0;
			restarts_seen        = '0;
			seeded               = 1'b0;
			errors               = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_RESTART_ENABLE:   restart_en = data[0];
				CFG_MIN_RUN:          min_run = data[MIN_RUN_W-1:0];
				CFG_FAST_ALPHA:       fast_alpha = data[ALPHA_W-1:0];
				CFG_SLOW_ALPHA:       slow_alpha = data[ALPHA_W-1:0];
				CFG_FOCUSED_TRIGGER:  focused_trig = data[TRIG_W-1:0];
				CFG_STABLE_EMERGENCY: emergency_trig = data[TRIG_W-1:0];
				CFG_STABLE_FLOOR:     floor_trig = data[TRIG_W-1:0];
				default: ;
			endcase
		endfunction

		// avg + round(alpha * (x - avg) / 2^16), floor-rounded shift, clamped
		function logic [AVG_W-1:0] ema_step(logic [AVG_W-1:0] avg, logic [AVG_W-1:0] x,
				logic [ALPHA_W-1:0] alpha);
			longint prod;
			longint res;
			prod = (longint'(x) - longint'(avg)) * longint'(alpha) + 32768;
			res = longint'(avg) + (prod >>> 16);
			if (res < 0)
				res = 0;
			if (res > longint'(32'hFFFF_FFFF))
				res = longint'(32'hFFFF_FFFF);
			return res[AVG_W-1:0];
		endfunction

		// fast/slow against a Q2.16 level by cross-multiplication
		function bit ratio_beyond(logic [TRIG_W-1:0] t, bit strict);
			logic [63:0] lhs;
			logic [63:0] rhs;
			if (slow_avg == '0) begin
				lhs = 64'(ONE_Q16);
				rhs = 64'(t);
			end else begin
				lhs = {16'd0, fast_avg, 16'd0};
				rhs = 64'(t) * 64'(slow_avg);
			end
			return strict ? (lhs > rhs) : (lhs >= rhs);
		endfunction

		function void note_query(query_t q);
			bit                 give;
			logic [AVG_W-1:0]   x;
			logic [FIELD_W-1:0] conf_gap;
			give = 1'b0;
			if (restart_en && q.level != '0) begin
				if (q.restarts > restarts_seen) begin
					conflicts_at_restart = q.conflicts;
					restarts_seen = q.restarts;
				end
				if (q.learned > learned_seen) begin
					x = {q.glue, 8'd0};
					if (!seeded) begin
						fast_avg = x;
						slow_avg = x;
						seeded = 1'b1;
						conflicts_at_restart = q.conflicts;
					end else begin
						fast_avg = ema_step(fast_avg, x, fast_alpha);
						slow_avg = ema_step(slow_avg, x, slow_alpha);
					end
					learned_seen = q.learned;
				end
				conf_gap = q.conflicts - conflicts_at_restart;
				if (seeded && conf_gap >= FIELD_W'(min_run)) begin
					if (!q.stable)
						give = ratio_beyond(focused_trig, 1'b1);
					else
						give = ratio_beyond(emergency_trig, 1'b1) ||
							(q.reluctant && ratio_beyond(floor_trig, 1'b0));
					if (give) begin
						conflicts_at_restart = q.conflicts;
						restarts_seen = q.restarts + 1'b1;
					end
				end
			end
			answers.push_back(give);
		endfunction

		function void check_answer(logic got);
			bit want;
			if (answers.size() == 0) begin
				$error("do_restart: result with no query outstanding, actual %0b", got);
				errors++;
				return;
			end
			want = answers.pop_front();
			if (got !== want) begin
				$error("do_restart mismatch: expected %0b, actual %0b", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return answers.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FIELD_W-1:0]    restart_count = '0;
	logic [FIELD_W-1:0]    conflict_count = '0;
	logic [FIELD_W-1:0]    learned_count = '0;
	logic [GLUE_W-1:0]     glue_average = '0;
	logic [LEVEL_W-1:0]    decision_level = '0;
	logic                  stable_mode = 1'b0;
	logic                  reluctant_triggered = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  do_restart;

	restart_sb          sb;
	bit                 calm = 1'b0;
	int                 stall_left = 0;
	int                 quiet_cycles = 0;
	logic [FIELD_W-1:0] s_conf;
	logic [GLUE_W-1:0]  s_glue;
	logic               s_stable;

	ema_ratio_restart_policy_core u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// answer side: random stall bursts, result check, watchdog
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_answer(do_restart);
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ema_ratio_restart_policy_core verification failed");
			$finish;
		end
	end

	function automatic query_t mkq(input logic [FIELD_W-1:0] r, c, l,
			input logic [GLUE_W-1:0] g, input logic [LEVEL_W-1:0] lv,
			input logic st, rl);
		query_t q;
		q = '{restarts: r, conflicts: c, learned: l, glue: g, level: lv,
			stable: st, reluctant: rl};
		return q;
	endfunction

	task automatic send_query(query_t q);
		in_valid <= 1'b1;
		restart_count <= q.restarts;
		conflict_count <= q.conflicts;
		learned_count <= q.learned;
		glue_average <= q.glue;
		decision_level <= q.level;
		stable_mode <= q.stable;
		reluctant_triggered <= q.reluctant;
		do @(posedge clk); while (!in_ready);
		sb.note_query(q);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// stop sending and let every outstanding answer drain
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// junk in the unused upper bits checks the masking
	task automatic apply_config(policy_cfg_t c);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_RESTART_ENABLE, {junk[CFG_DATA_W-1:1], c.enable});
		write_reg(CFG_MIN_RUN, {junk[CFG_DATA_W-1:MIN_RUN_W], c.min_run});
		write_reg(CFG_FAST_ALPHA, {junk[CFG_DATA_W-1:ALPHA_W], c.fast_alpha});
		write_reg(CFG_SLOW_ALPHA, {junk[CFG_DATA_W-2:ALPHA_W-1], c.slow_alpha});
		write_reg(CFG_FOCUSED_TRIGGER, c.focused);
		write_reg(CFG_STABLE_EMERGENCY, c.emergency);
		write_reg(CFG_STABLE_FLOOR, c.floor);
		write_reg(CFG_UNMAPPED, junk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(policy_cfg_t c, int count);
		query_t q;
		int     pick;
		int     g;
		settle();
		apply_config(c);
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			s_conf = s_conf + $urandom_range(0, 12);
			if ($urandom_range(0, 19) == 0) begin
				s_glue = GLUE_W'($urandom_range(24'h004000, 24'h400000));
			end else begin
				g = int'(s_glue) + int'($urandom_range(0, 4096)) - 2048;
				if (g < 0)
					g = 0;
				if (g > 24'hFFFFFF)
					g = 24'hFFFFFF;
				s_glue = g[GLUE_W-1:0];
			end
			if ($urandom_range(0, 49) == 0)
				s_stable = !s_stable;
			// solver-like query: counters move forward, restarts follow answers
			q.restarts = sb.restarts_seen;
			if ($urandom_range(0, 29) == 0)
				q.restarts = q.restarts + $urandom_range(1, 4);
			q.conflicts = s_conf;
			q.learned = sb.learned_seen;
			if ($urandom_range(0, 9) < 7)
				q.learned = q.learned + $urandom_range(1, 3);
			q.glue = s_glue;
			q.level = ($urandom_range(0, 31) == 0) ? '0 : LEVEL_W'($urandom_range(1, 400));
			q.stable = s_stable;
			q.reluctant = ($urandom_range(0, 4) == 0);
			if (pick < 4) begin
				q.restarts = $urandom;
				q.conflicts = $urandom;
				q.learned = $urandom;
				q.glue = GLUE_W'($urandom);
				q.level = LEVEL_W'($urandom);
				q.stable = 1'($urandom_range(0, 1));
				q.reluctant = 1'($urandom_range(0, 1));
			end else if (pick < 8) begin
				// counters stepping backwards
				q.conflicts = s_conf - $urandom_range(0, 200);
				q.learned = sb.learned_seen - $urandom_range(0, 3);
			end
			send_query(q);
		end
	endtask

	initial begin
		policy_cfg_t c;
		sb = new();
		s_conf = 32'h0000_0200;
		s_glue = 24'h010000;
		s_stable = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, register defaults
		send_query(mkq(0, 0, 5, 24'h123456, 0, 1'b0, 1'b0));      // level zero
		send_query(mkq(0, 10, 0, 24'h010000, 1, 1'b0, 1'b0));     // not seeded yet
		send_query(mkq(0, 100, 1, 24'h000000, 1, 1'b0, 1'b0));    // seed with zero glue
		send_query(mkq(0, 150, 1, 24'h000000, 2, 1'b0, 1'b0));    // slow zero, ratio one
		send_query(mkq(0, 160, 1, 24'h000000, 3, 1'b1, 1'b1));    // reluctant over floor
		send_query(mkq(1, 260, 2, 24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0));
		send_query(mkq(2, 280, 2, 24'hFFFFFF, 4, 1'b1, 1'b1));    // inside min run
		send_query(mkq(9, 300, 3, 24'h010000, 5, 1'b1, 1'b0));    // external restart
		send_query(mkq(9, 360, 3, 24'h010000, 6, 1'b1, 1'b0));    // emergency
		send_query(mkq(10, 409, 4, 24'h020000, 7, 1'b0, 1'b1));   // one short of min run
		send_query(mkq(10, 410, 4, 24'h020000, 8, 1'b0, 1'b1));   // exactly min run
		send_query(mkq(32'hFFFF_FFFF, 32'hFFFF_FFF0, 5, 24'h000000, 9, 1'b1, 1'b1));
		send_query(mkq(32'hFFFF_FFFF, 32'h0000_0040, 6, 24'h000001, 10, 1'b0, 1'b0));
		send_query(mkq(32'hFFFF_FFFF, 32'h0000_00A0, 7, 24'h800000, 11, 1'b1, 1'b1));
		send_query(mkq(0, 32'h0000_0100, 8, 24'h7FFFFF, 12, 1'b0, 1'b1));

		c = '{1'b0, RST_MIN_RUN, RST_FAST_ALPHA, RST_SLOW_ALPHA, RST_FOCUSED_TRIGGER,
			RST_STABLE_EMERGENCY, RST_STABLE_FLOOR};
		run_phase(c, 60);
		c.enable = 1'b1;
		run_phase(c, 250);
		c = '{1'b1, 16'd0, 16'hFFFF, 16'd0, 18'd0, 18'd0, 18'd0};
		run_phase(c, 200);
		c = '{1'b1, 16'hFFFF, 16'd0, 16'd0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF};
		run_phase(c, 150);
		c = '{1'b1, 16'd5, 16'd20000, 16'd500, 18'd70000, 18'd80000, 18'd60000};
		run_phase(c, 300);
		c = '{1'b1, MIN_RUN_W'($urandom_range(0, 40)), ALPHA_W'($urandom),
			ALPHA_W'($urandom), TRIG_W'($urandom), TRIG_W'($urandom), TRIG_W'($urandom)};
		run_phase(c, 250);
		c = '{1'b1, 16'd10, 16'hFFFF, 16'hFFFF, 18'd65536, 18'd65536, 18'd65536};
		run_phase(c, 200);
		calm = 1'b1;
		c = '{1'b1, 16'd20, 16'd8000, 16'd300, 18'd68000, 18'd85000, 18'd62000};
		run_phase(c, 350);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ema_ratio_restart_policy_core verification clean");
		else
			$display("ema_ratio_restart_policy_core verification failed");
		$finish;
	end

endmodule
